// File: rtl/scc_pkg.sv
// Shared types, constants and helper functions for the stepper clock command controller.
// No dependencies; every other file refers to it by scoped names.
package scc_pkg;

    localparam int unsigned NUM_W   = 15;       // command numbers saturate at 32767
    localparam int unsigned POS_W   = 16;
    localparam logic [NUM_W-1:0] NUM_MAX = 15'd32767;
    localparam logic [7:0] CTRL_SET  = 8'h1E;
    localparam logic [7:0] COIL_OFF  = 8'h88;
    localparam logic [7:0] CTRL_STB0 = 8'h80;
    localparam logic [7:0] CTRL_STB1 = 8'h40;
    localparam logic [7:0] CTRL_STB2 = 8'h20;
    localparam logic [7:0] COLON_BIT = 8'h80;
    localparam logic [6:0] SINCE_MAX = 7'd127;
    // reciprocal of 50 scaled by 2^20, exact for numbers up to 32767
    localparam logic [NUM_W-1:0] DIV50_MUL = 15'd20972;
    localparam int unsigned DIV50_SHIFT = 20;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_Y_LO  = 8'h79;
    localparam logic [7:0] CH_L_LO  = 8'h6C;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_U_LO  = 8'h75;
    localparam logic [7:0] CH_D_LO  = 8'h64;
    localparam logic [7:0] CH_L_UP  = 8'h4C;
    localparam logic [7:0] CH_R_UP  = 8'h52;
    localparam logic [7:0] CH_U_UP  = 8'h55;
    localparam logic [7:0] CH_D_UP  = 8'h44;
    localparam logic [7:0] CH_S_LO  = 8'h73;
    localparam logic [7:0] CH_S_UP  = 8'h53;
    localparam logic [7:0] CH_T_UP  = 8'h54;
    localparam logic [7:0] CH_M_UP  = 8'h4D;

    localparam logic [2:0] WR_LAST = 3'd6;

    typedef struct packed {
        logic       mode;
        logic [7:0] cmd_byte;
        logic       end_of_write;
    } t_in_item;

    typedef struct packed {
        logic                    port_select;
        logic [7:0]              port_value;
        logic                    last_write;
        logic signed [POS_W-1:0] current_x;
        logic signed [POS_W-1:0] current_y;
        logic [9:0]              load_level;
    } t_out_item;

    // everything one refreshing or stepping tick hands to the write sequencer
    typedef struct packed {
        logic [7:0]              coil;
        logic [7:0]              ctrl;
        logic [7:0]              left;
        logic [7:0]              right;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [NUM_W-1:0]        load_num;
    } t_snap;

    typedef enum logic [5:0] {
        PS_IDLE   = 6'b000001,
        PS_SIGN   = 6'b000010,
        PS_DIGITS = 6'b000100,
        PS_SPEED  = 6'b001000,
        PS_TIME   = 6'b010000,
        PS_LOAD   = 6'b100000
    } t_pstate;

    typedef enum logic [2:0] {
        PC_NONE = 3'd0,
        PC_X    = 3'd1,
        PC_Y    = 3'd2,
        PC_L    = 3'd3,
        PC_R    = 3'd4,
        PC_U    = 3'd5,
        PC_D    = 3'd6
    } t_pcmd;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd1:    s = 8'h44;
            4'd2:    s = 8'h6B;
            4'd3:    s = 8'h6E;
            4'd4:    s = 8'h56;
            4'd5:    s = 8'h3E;
            4'd6:    s = 8'h3F;
            4'd7:    s = 8'h64;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h7E;
            default: s = 8'h7D;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] speed_limit(input logic [3:0] idx);
        logic [6:0] l;
        case (idx)
            4'd1:    l = 7'd75;
            4'd2:    l = 7'd50;
            4'd3:    l = 7'd25;
            4'd4:    l = 7'd20;
            4'd5:    l = 7'd10;
            4'd6:    l = 7'd8;
            4'd7:    l = 7'd6;
            4'd8:    l = 7'd4;
            4'd9:    l = 7'd2;
            default: l = 7'd100;
        endcase
        return l;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // clamp to +/- 32767
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [20:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 21'sd32767) begin
            r = 16'sd32767;
        end else if (v < -21'sd32767) begin
            r = -16'sd32767;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/stepper_clock_command_controller.sv
// Stepper clock command controller, top level. Command bytes and ticks enter one per cycle
// while full is low; a tick that refreshes or steps queues a snapshot, read out as seven
// writes one per cycle while pop is held. The queue registers each snapshot before its
// first write shows. Each emitting tick holds the write side through its writes, with
// QUEUE_DEPTH snapshots buffered. full rises only when the queue is full.
// Reset: synchronous, active low; clears all control and machine state.
module stepper_clock_command_controller #(
    parameter int unsigned BLINK_TICKS = 50,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  scc_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output scc_pkg::t_out_item o_result
);

    logic           accept, snap_valid, release_snap;
    scc_pkg::t_snap snap_in, snap_head;

    assign accept = push && !full;

    scc_front #(.BLINK_TICKS(BLINK_TICKS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_item),
        .o_snap_valid (snap_valid),
        .o_snap       (snap_in)
    );

    scc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (snap_valid),
        .i_data  (snap_in),
        .i_rd    (release_snap),
        .o_data  (snap_head),
        .o_full  (full),
        .o_empty (empty)
    );

    scc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_avail   (!empty),
        .i_snap    (snap_head),
        .i_take    (pop),
        .o_release (release_snap),
        .o_item    (o_result)
    );

endmodule

// File: rtl/scc_front.sv
// Front end: parses command bytes, runs the tick timing and stepping, and
// emits one snapshot per tick that needs port writes. Uses scc_pkg.
module scc_front #(
    parameter int unsigned BLINK_TICKS = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  scc_pkg::t_in_item i_item,
    output logic              o_snap_valid,
    output scc_pkg::t_snap    o_snap
);

    localparam int unsigned BW = (BLINK_TICKS > 1) ? $clog2(BLINK_TICKS) : 1;
    localparam logic [BW-1:0] BLINK_LAST = BW'(BLINK_TICKS - 1);
    localparam int unsigned NW = scc_pkg::NUM_W;
    localparam int unsigned PW = scc_pkg::POS_W;

    logic [BW-1:0]        r_blink, n_blink;
    logic [2:0]           r_phase, n_phase;
    logic [6:0]           r_since, n_since;
    logic signed [PW-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic signed [PW-1:0] r_tgt_x, n_tgt_x, r_tgt_y, n_tgt_y;
    logic [3:0]           r_speed, n_speed;
    logic [7:0]           r_ctrl, n_ctrl, r_left, n_left, r_right, n_right, r_coil, n_coil;
    logic [3:0]           r_digit [4];
    logic [3:0]           n_digit [4];
    logic [NW-1:0]        r_load, n_load;
    scc_pkg::t_pstate     r_ps, n_ps;
    scc_pkg::t_pcmd       r_pc, n_pc;
    logic [NW-1:0]        r_acc, n_acc;
    logic                 r_neg, n_neg;
    logic [1:0]           r_slot, n_slot;
    logic                 r_ten, n_ten;
    logic                 n_emit;

    always_comb begin
        logic [7:0]           b;
        logic                 dig;
        logic [3:0]           dv;
        logic [NW+3:0]        wide;
        logic [NW-1:0]        acc_dig;
        logic                 do_fin, do_idle, started;
        logic [NW-1:0]        f_acc;
        logic                 f_neg;
        logic signed [20:0]   f_n;
        logic signed [20:0]   f_n10;
        logic [6:0]           lim;

        n_blink = r_blink;  n_phase = r_phase;  n_since = r_since;
        n_pos_x = r_pos_x;  n_pos_y = r_pos_y;  n_tgt_x = r_tgt_x;  n_tgt_y = r_tgt_y;
        n_speed = r_speed;  n_ctrl = r_ctrl;    n_left = r_left;    n_right = r_right;
        n_coil = r_coil;    n_digit = r_digit;  n_load = r_load;    n_ps = r_ps;
        n_pc = r_pc;        n_acc = r_acc;      n_neg = r_neg;      n_slot = r_slot;
        n_ten = r_ten;      n_emit = 1'b0;

        b   = i_item.cmd_byte;
        dig = scc_pkg::is_digit(b);
        dv  = 4'(b - scc_pkg::CH_ZERO);
        wide = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {{NW{1'b0}}, dv};
        acc_dig = (wide > {4'd0, scc_pkg::NUM_MAX}) ? scc_pkg::NUM_MAX : wide[NW-1:0];

        do_fin  = 1'b0;
        do_idle = 1'b0;
        started = 1'b0;
        f_acc   = r_acc;
        f_neg   = r_neg;
        f_n     = '0;
        f_n10   = '0;
        lim     = '0;

        if (i_accept && i_item.mode) begin
            case (r_ps)
                scc_pkg::PS_SIGN, scc_pkg::PS_DIGITS: begin
                    if (r_ps == scc_pkg::PS_SIGN && b == scc_pkg::CH_MINUS) begin
                        n_neg = 1'b1;
                        n_ps  = scc_pkg::PS_DIGITS;
                        f_neg = 1'b1;
                        do_fin = i_item.end_of_write;
                    end else if (dig) begin
                        n_acc = acc_dig;
                        n_ps  = scc_pkg::PS_DIGITS;
                        f_acc = acc_dig;
                        do_fin = i_item.end_of_write;
                    end else begin
                        do_fin  = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                scc_pkg::PS_SPEED: begin
                    if (dig) begin
                        n_speed = dv;
                    end
                    n_ps = scc_pkg::PS_IDLE;
                end
                scc_pkg::PS_TIME: begin
                    if (dig) begin
                        n_digit[r_slot] = dv;
                        n_slot = r_slot + 2'd1;
                        if (r_slot == 2'd3) begin
                            n_ps = scc_pkg::PS_IDLE;
                        end
                    end
                end
                scc_pkg::PS_LOAD: begin
                    if (b == scc_pkg::CH_NL) begin
                        n_load = r_acc;
                        n_ps   = scc_pkg::PS_IDLE;
                    end else if (dig) begin
                        n_acc = acc_dig;
                    end
                end
                default: begin
                    n_ps    = scc_pkg::PS_IDLE;
                    do_idle = 1'b1;
                end
            endcase

            // complete the pending move with the number as it stands
            if (do_fin) begin
                f_n = f_neg ? -$signed({6'd0, f_acc}) : $signed({6'd0, f_acc});
                f_n10 = (f_n <<< 3) + (f_n <<< 1);
                if (r_ten) begin
                    f_n = 21'(scc_pkg::sat_pos(f_n10));
                end
                case (r_pc)
                    scc_pkg::PC_X: n_tgt_x = scc_pkg::sat_pos(f_n);
                    scc_pkg::PC_Y: n_tgt_y = scc_pkg::sat_pos(f_n);
                    scc_pkg::PC_L: n_tgt_x = scc_pkg::sat_pos(21'(r_tgt_x) - f_n);
                    scc_pkg::PC_R: n_tgt_x = scc_pkg::sat_pos(21'(r_tgt_x) + f_n);
                    scc_pkg::PC_U: n_tgt_y = scc_pkg::sat_pos(21'(r_tgt_y) + f_n);
                    scc_pkg::PC_D: n_tgt_y = scc_pkg::sat_pos(21'(r_tgt_y) - f_n);
                    default: ;
                endcase
                n_pc = scc_pkg::PC_NONE;
                n_ps = scc_pkg::PS_IDLE;
            end

            if (do_idle) begin
                case (b)
                    scc_pkg::CH_X_LO, scc_pkg::CH_Y_LO, scc_pkg::CH_L_LO, scc_pkg::CH_R_LO,
                    scc_pkg::CH_U_LO, scc_pkg::CH_D_LO, scc_pkg::CH_L_UP, scc_pkg::CH_R_UP,
                    scc_pkg::CH_U_UP, scc_pkg::CH_D_UP: begin
                        started = 1'b1;
                        n_acc = '0;
                        n_neg = 1'b0;
                        n_ps  = scc_pkg::PS_SIGN;
                        n_ten = (b < 8'h60);
                        case (b)
                            scc_pkg::CH_X_LO: n_pc = scc_pkg::PC_X;
                            scc_pkg::CH_Y_LO: n_pc = scc_pkg::PC_Y;
                            scc_pkg::CH_L_LO, scc_pkg::CH_L_UP: n_pc = scc_pkg::PC_L;
                            scc_pkg::CH_R_LO, scc_pkg::CH_R_UP: n_pc = scc_pkg::PC_R;
                            scc_pkg::CH_U_LO, scc_pkg::CH_U_UP: n_pc = scc_pkg::PC_U;
                            default: n_pc = scc_pkg::PC_D;
                        endcase
                    end
                    scc_pkg::CH_MINUS: n_coil = scc_pkg::COIL_OFF;
                    scc_pkg::CH_S_LO, scc_pkg::CH_S_UP: n_ps = scc_pkg::PS_SPEED;
                    scc_pkg::CH_BANG: begin
                        n_pos_x = '0;  n_pos_y = '0;
                        n_tgt_x = '0;  n_tgt_y = '0;
                    end
                    scc_pkg::CH_T_UP: begin
                        n_slot = '0;
                        n_ps   = scc_pkg::PS_TIME;
                    end
                    scc_pkg::CH_M_UP: begin
                        n_acc = '0;
                        n_ps  = scc_pkg::PS_LOAD;
                    end
                    default: ;
                endcase
            end

            if (i_item.end_of_write) begin
                // a move opened by this very byte completes with zero
                if (started) begin
                    if (n_pc == scc_pkg::PC_X) begin
                        n_tgt_x = '0;
                    end else if (n_pc == scc_pkg::PC_Y) begin
                        n_tgt_y = '0;
                    end
                    n_pc = scc_pkg::PC_NONE;
                end
                if (n_ps == scc_pkg::PS_SPEED) begin
                    n_speed = '0;
                end
                if (n_ps == scc_pkg::PS_LOAD) begin
                    n_load = n_acc;
                end
                n_ps   = scc_pkg::PS_IDLE;
                n_slot = '0;
            end
        end

        if (i_accept && !i_item.mode) begin
            if (r_blink == '0) begin
                n_ctrl = (r_ctrl ^ 8'h01) | scc_pkg::CTRL_SET;
                if (r_phase[2:1] != 2'd0) begin
                    n_left  = scc_pkg::seg_of(r_digit[2]);
                    n_right = scc_pkg::seg_of(r_digit[3]);
                end else begin
                    n_left  = scc_pkg::seg_of(r_digit[0]);
                    n_right = scc_pkg::seg_of(r_digit[1]) | scc_pkg::COLON_BIT;
                end
                n_emit = 1'b1;
            end
            n_since = (r_since < scc_pkg::SINCE_MAX) ? r_since + 7'd1 : r_since;
            lim = scc_pkg::speed_limit(r_speed);
            if (n_since > lim && (r_pos_x != r_tgt_x || r_pos_y != r_tgt_y)) begin
                if (r_tgt_x > r_pos_x) begin
                    n_pos_x = r_pos_x + 16'sd1;
                end else if (r_tgt_x < r_pos_x) begin
                    n_pos_x = r_pos_x - 16'sd1;
                end
                if (r_tgt_y > r_pos_y) begin
                    n_pos_y = r_pos_y + 16'sd1;
                end else if (r_tgt_y < r_pos_y) begin
                    n_pos_y = r_pos_y - 16'sd1;
                end
                n_coil  = {1'b0, n_pos_y[2:0], 1'b0, n_pos_x[2:0]};
                n_since = '0;
                n_emit  = 1'b1;
            end
            if (r_blink == BLINK_LAST) begin
                n_blink = '0;
                n_phase = r_phase + 3'd1;
            end else begin
                n_blink = r_blink + BW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink <= '0;  r_phase <= '0;  r_since <= scc_pkg::SINCE_MAX;
            r_pos_x <= '0;  r_pos_y <= '0;  r_tgt_x <= '0;  r_tgt_y <= '0;
            r_speed <= '0;  r_ctrl <= '0;   r_left <= '0;   r_right <= '0;
            r_coil  <= '0;  r_load <= '0;   r_ps <= scc_pkg::PS_IDLE;
            r_pc    <= scc_pkg::PC_NONE;    r_acc <= '0;    r_neg <= 1'b0;
            r_slot  <= '0;  r_ten <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_digit[i] <= '0;
            end
        end else begin
            r_blink <= n_blink;  r_phase <= n_phase;  r_since <= n_since;
            r_pos_x <= n_pos_x;  r_pos_y <= n_pos_y;  r_tgt_x <= n_tgt_x;  r_tgt_y <= n_tgt_y;
            r_speed <= n_speed;  r_ctrl <= n_ctrl;    r_left <= n_left;    r_right <= n_right;
            r_coil  <= n_coil;   r_load <= n_load;    r_ps <= n_ps;        r_pc <= n_pc;
            r_acc   <= n_acc;    r_neg <= n_neg;      r_slot <= n_slot;    r_ten <= n_ten;
            r_digit <= n_digit;
        end
    end

    assign o_snap_valid   = n_emit;
    assign o_snap.coil     = n_coil;
    assign o_snap.ctrl     = n_ctrl;
    assign o_snap.left     = n_left;
    assign o_snap.right    = n_right;
    assign o_snap.pos_x    = n_pos_x;
    assign o_snap.pos_y    = n_pos_y;
    assign o_snap.load_num = r_load;

endmodule

// File: rtl/scc_fifo.sv
// Short snapshot queue between the parser front end and the write sequencer.
// Depends on scc_pkg for the snapshot type.
module scc_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  scc_pkg::t_snap i_data,
    input  logic           i_rd,
    output scc_pkg::t_snap o_data,
    output logic           o_full,
    output logic           o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    scc_pkg::t_snap r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
            end
            if (i_rd) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + AW'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// File: rtl/scc_back.sv
// Back end: walks one queued snapshot through its seven port writes.
// Depends on scc_pkg for the snapshot and result types.
module scc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  scc_pkg::t_snap    i_snap,
    input  logic              i_take,
    output logic              o_release,
    output scc_pkg::t_out_item o_item
);

    logic [2:0] r_wr;
    logic [2*scc_pkg::NUM_W-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
        end else if (i_avail && i_take) begin
            r_wr <= (r_wr == scc_pkg::WR_LAST) ? 3'd0 : r_wr + 3'd1;
        end
    end

    assign o_release = i_avail && i_take && (r_wr == scc_pkg::WR_LAST);

    // load / 50 by reciprocal multiply
    assign prod = i_snap.load_num * scc_pkg::DIV50_MUL;

    always_comb begin
        o_item.last_write = (r_wr == scc_pkg::WR_LAST);
        o_item.current_x  = i_snap.pos_x;
        o_item.current_y  = i_snap.pos_y;
        o_item.load_level = prod[scc_pkg::DIV50_SHIFT +: 10];
        case (r_wr)
            3'd0: begin o_item.port_select = 1'b1; o_item.port_value = i_snap.coil; end
            3'd1: begin
                o_item.port_select = 1'b0;
                o_item.port_value  = i_snap.ctrl | scc_pkg::CTRL_STB0;
            end
            3'd2: begin o_item.port_select = 1'b1; o_item.port_value = i_snap.right; end
            3'd3: begin
                o_item.port_select = 1'b0;
                o_item.port_value  = i_snap.ctrl | scc_pkg::CTRL_STB1;
            end
            3'd4: begin o_item.port_select = 1'b1; o_item.port_value = i_snap.left; end
            3'd5: begin
                o_item.port_select = 1'b0;
                o_item.port_value  = i_snap.ctrl | scc_pkg::CTRL_STB2;
            end
            default: begin o_item.port_select = 1'b0; o_item.port_value = i_snap.ctrl; end
        endcase
    end

endmodule

// File: rtl/scc_checker.sv
// Port-level checks for the stepper clock command controller, bound to the top level.
// Depends on scc_pkg for the result type.
module scc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input scc_pkg::t_out_item o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results pending after reset");

    a_group_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last_write) |=> !empty)
        else $error("write group broken up");

    a_group_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last_write)
            |=> ($stable(o_result.current_x) && $stable(o_result.current_y)))
        else $error("positions changed inside a write group");

    a_last_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.last_write) |-> !o_result.port_select)
        else $error("final write not to control port");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> !full)
        else $error("full while empty");

endmodule

bind stepper_clock_command_controller scc_checker u_scc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
